@@ hdl/tcce_pkg.sv @@
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

    localparam int COLS          = 64;
    localparam int STORE_CELLS   = 4096;
    localparam int VISIBLE_CELLS = 1920;
    localparam int GLYPH_H       = 16;
    localparam int GLYPH_W       = 8;
    localparam int BACK_ROW      = 32;
    localparam int JQ_DEPTH      = 4;
    localparam int JQ_AW         = $clog2(JQ_DEPTH);

    localparam logic [2:0] CMD_PUT    = 3'd0;
    localparam logic [2:0] CMD_BACK   = 3'd1;
    localparam logic [2:0] CMD_LOCK   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_SWITCH = 3'd4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [7:0] WHITE_RESET = 8'd255;

    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_ERASE  = 3'd1,
        K_LINE   = 3'd2,
        K_REGION = 3'd3,
        K_CURSOR = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        TAIL_NONE   = 2'd0,
        TAIL_CURSOR = 2'd1,
        TAIL_REGION = 2'd2
    } t_tail;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [7:0] color_byte;
    } t_cmd_item;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] address;
        logic [7:0]  out_char;
        logic [7:0]  out_color;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [5:0]  scroll_lines;
        logic        last;
    } t_res_item;

    // one decoded command: a run of cell writes, an optional row clear
    // slotted in after line_pos writes, and an optional closing result
    typedef struct packed {
        logic [2:0]  wr_cnt;
        t_kind       wr_kind;
        logic [11:0] wr_addr;
        logic [7:0]  wr_char;
        logic [7:0]  wr_color;
        logic [7:0]  fill_color;
        logic        has_line;
        logic [2:0]  line_pos;
        logic [11:0] line_addr;
        t_tail       tail;
        logic        recomp;
        logic [11:0] wc_final;
        logic [5:0]  lo_final;
    } t_job;

endpackage

@@ hdl/tcce_jobq.sv @@
// Small job queue between the command decoder and the result sequencer.
module tcce_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  tcce_pkg::t_job i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output tcce_pkg::t_job o_rdata,
    output logic           o_empty
);
    import tcce_pkg::*;

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wptr;
    logic [JQ_AW-1:0] r_rptr;
    logic [JQ_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (JQ_AW + 1)'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hdl/tcce_front.sv @@
// Command decoder: cursor state, wrap and scroll decisions, job build.
module tcce_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_accept,
    input  tcce_pkg::t_cmd_item i_item,
    output tcce_pkg::t_job      o_job,
    output logic                o_job_wr
);
    import tcce_pkg::*;

    localparam logic [11:0] VIS_CELLS = 12'(VISIBLE_CELLS);
    localparam logic [11:0] BACK_BASE = 12'(BACK_ROW * COLS);
    localparam logic [5:0]  BACK_LO   = 6'(BACK_ROW);

    logic [7:0]  r_white;
    logic [11:0] r_wc;
    logic [11:0] r_front;
    logic [11:0] r_bc;
    logic        r_shown;
    logic [5:0]  r_lo;

    logic [11:0] n_wc;
    logic [11:0] n_front;
    logic [11:0] n_bc;
    logic        n_shown;
    logic [5:0]  n_lo;
    logic        known;
    t_job        job;
    logic [11:0] target;
    logic [11:0] wc_nl;
    logic [11:0] wc_k;
    logic        hit;

    always_comb begin
        target  = VIS_CELLS + {r_lo, 6'b0};
        wc_nl   = {r_wc[11:6] + 6'd1, 6'b0};
        wc_k    = '0;
        hit     = 1'b0;
        n_wc    = r_wc;
        n_front = r_front;
        n_bc    = r_bc;
        n_shown = r_shown;
        n_lo    = r_lo;
        known   = 1'b1;
        job     = '0;
        job.wr_kind    = K_WRITE;
        job.tail       = TAIL_NONE;
        job.fill_color = r_white;

        unique case (i_item.cmd)
            CMD_PUT: begin
                job.recomp = 1'b1;
                case (i_item.char_code)
                    CH_NL: begin
                        n_wc = wc_nl;
                        if (wc_nl == target) begin
                            job.has_line  = 1'b1;
                            job.line_addr = wc_nl;
                            n_lo          = r_lo + 6'd1;
                        end else begin
                            job.tail = TAIL_CURSOR;
                        end
                    end
                    CH_TAB: begin
                        job.wr_cnt   = 3'd4;
                        job.wr_addr  = r_wc;
                        job.wr_char  = CH_SPACE;
                        job.wr_color = r_white;
                        n_wc         = r_wc + 12'd4;
                        for (int k = 1; k <= 4; k++) begin
                            wc_k = r_wc + 12'(k);
                            if (!hit && wc_k == target) begin
                                hit           = 1'b1;
                                job.has_line  = 1'b1;
                                job.line_pos  = 3'(k);
                                job.line_addr = wc_k;
                            end
                        end
                        if (hit) begin
                            n_lo = r_lo + 6'd1;
                        end
                    end
                    CH_BS: begin
                        if (r_front < r_wc) begin
                            n_wc        = r_wc - 12'd1;
                            job.wr_cnt  = 3'd1;
                            job.wr_kind = K_ERASE;
                            job.wr_addr = r_wc - 12'd1;
                        end else begin
                            job.tail = TAIL_CURSOR;
                        end
                    end
                    default: begin
                        job.wr_cnt   = 3'd1;
                        job.wr_addr  = r_wc;
                        job.wr_char  = i_item.char_code;
                        job.wr_color = i_item.color_byte;
                        n_wc         = r_wc + 12'd1;
                        if (n_wc == target) begin
                            job.has_line  = 1'b1;
                            job.line_pos  = 3'd1;
                            job.line_addr = n_wc;
                            n_lo          = r_lo + 6'd1;
                        end
                    end
                endcase
            end
            CMD_BACK: begin
                job.wr_cnt   = 3'd1;
                job.wr_addr  = r_bc;
                job.wr_char  = i_item.char_code;
                job.wr_color = i_item.color_byte;
                n_bc         = r_bc + 12'd1;
            end
            CMD_LOCK: begin
                n_front  = r_wc;
                job.tail = TAIL_CURSOR;
            end
            CMD_CLEAR: begin
                job.tail   = TAIL_REGION;
                job.recomp = 1'b1;
                n_wc       = '0;
                n_front    = '0;
                n_bc       = '0;
                n_shown    = 1'b0;
                n_lo       = '0;
            end
            CMD_SWITCH: begin
                job.tail = TAIL_CURSOR;
                n_shown  = !r_shown;
                if (!r_shown) begin
                    n_wc = BACK_BASE;
                    n_bc = '0;
                    n_lo = BACK_LO;
                end else begin
                    n_wc = '0;
                    n_bc = BACK_BASE;
                    n_lo = '0;
                end
            end
            default: begin
                known = 1'b0;
            end
        endcase

        job.wc_final = n_wc;
        job.lo_final = n_lo;
    end

    assign o_job    = job;
    assign o_job_wr = i_accept && known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= WHITE_RESET;
        end else if (i_cfg_we) begin
            r_white <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc    <= '0;
            r_front <= '0;
            r_bc    <= '0;
            r_shown <= 1'b0;
            r_lo    <= '0;
        end else if (o_job_wr) begin
            r_wc    <= n_wc;
            r_front <= n_front;
            r_bc    <= n_bc;
            r_shown <= n_shown;
            r_lo    <= n_lo;
        end
    end

endmodule

@@ hdl/tcce_back.sv @@
// Result sequencer: expands each job into items and holds the output register.
module tcce_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcce_pkg::t_job      i_job,
    input  logic                i_job_empty,
    output logic                o_job_rd,
    output tcce_pkg::t_res_item o_res,
    output logic                o_empty,
    input  logic                i_pop
);
    import tcce_pkg::*;

    logic [2:0]  r_widx;
    logic        r_line_done;
    logic [11:0] r_px;
    logic [11:0] r_py;
    t_res_item   r_out;
    logic        r_ov;

    logic        advance;
    logic        line_now;
    logic        wr_now;
    logic        last;
    logic [11:0] off;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [11:0] px;
    logic [11:0] py;
    t_res_item   res;

    always_comb begin
        off = i_job.wc_final - {i_job.lo_final, 6'b0};
        row = off[11:6];
        col = off[5:0];
        if (i_job.recomp) begin
            py = 12'(GLYPH_H * int'(row) + 1);
            px = (col == 6'(COLS - 1)) ? 12'd1 : 12'(GLYPH_W * int'(col) + 1);
        end else begin
            py = r_py;
            px = r_px;
        end

        line_now = i_job.has_line && !r_line_done && (r_widx == i_job.line_pos);
        wr_now   = !line_now && (r_widx < i_job.wr_cnt);
        last     = ((r_widx + 3'(wr_now)) == i_job.wr_cnt)
                   && !(i_job.has_line && !r_line_done && !line_now)
                   && !(i_job.tail != TAIL_NONE && (line_now || wr_now));

        res              = '0;
        res.kind         = K_CURSOR;
        res.pix_x        = px;
        res.pix_y        = py;
        res.scroll_lines = i_job.lo_final;
        res.last         = last;
        if (line_now) begin
            res.kind      = K_LINE;
            res.address   = i_job.line_addr;
            res.out_char  = CH_SPACE;
            res.out_color = i_job.fill_color;
        end else if (wr_now) begin
            res.kind      = i_job.wr_kind;
            res.address   = i_job.wr_addr + {9'b0, r_widx};
            res.out_char  = i_job.wr_char;
            res.out_color = i_job.wr_color;
        end else if (i_job.tail == TAIL_REGION) begin
            res.kind      = K_REGION;
            res.out_char  = CH_SPACE;
            res.out_color = i_job.fill_color;
        end
    end

    assign advance  = !i_job_empty && (!r_ov || i_pop);
    assign o_job_rd = advance && last;
    assign o_res    = r_out;
    assign o_empty  = !r_ov;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov        <= 1'b0;
            r_widx      <= '0;
            r_line_done <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
        end else begin
            if (advance) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (advance) begin
                if (last) begin
                    r_widx      <= '0;
                    r_line_done <= 1'b0;
                    r_px        <= px;
                    r_py        <= py;
                end else begin
                    r_widx      <= r_widx + 3'(wr_now);
                    r_line_done <= r_line_done || line_now;
                end
            end
        end
    end

endmodule

@@ hdl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine.
//
//  channel   handshake            payload
//  command   push / full          i_cmd_item  (cmd, char_code, color_byte)
//  result    empty / pop          o_res_item  (kind .. last)
//  config    i_cfg_we             i_cfg_wdata (white colour)
//
// A command is taken every cycle while the job queue (four deep) has room.
// Plain characters, backspace and the single-result commands give one item
// each; tab gives four or five items, a scrolling character two and a
// scrolling newline one. Items leave one a cycle while the receiver pops.
// The output register is the only result buffer.
// Reset clears all cursors, the line offset and the screen select.
module text_console_cursor_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tcce_pkg::t_cmd_item i_cmd_item,
    output logic                empty,
    input  logic                pop,
    output tcce_pkg::t_res_item o_res_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);
    import tcce_pkg::*;

    t_job job_in;
    t_job job_head;
    logic job_wr;
    logic job_rd;
    logic q_full;
    logic q_empty;

    assign full = q_full;

    tcce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (push && !q_full),
        .i_item      (i_cmd_item),
        .o_job       (job_in),
        .o_job_wr    (job_wr)
    );

    tcce_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_wdata (job_in),
        .o_full  (q_full),
        .i_rd    (job_rd),
        .o_rdata (job_head),
        .o_empty (q_empty)
    );

    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_empty (q_empty),
        .o_job_rd    (job_rd),
        .o_res       (o_res_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

`ifndef SYNTHESIS
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !job_wr)
        else $error("job queue written while full");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !job_rd)
        else $error("job queue read while empty");

    a_region_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res_item.kind == K_REGION) |->
            (o_res_item.last && o_res_item.scroll_lines == '0
             && o_res_item.pix_x == 12'd1 && o_res_item.pix_y == 12'd1))
        else $error("region clear item without home cursor");

    a_cursor_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res_item.kind == K_CURSOR) |->
            (o_res_item.last && o_res_item.address == '0
             && o_res_item.out_char == '0 && o_res_item.out_color == '0))
        else $error("cursor item carries cell data");
`endif

endmodule

@@ tb/text_console_cursor_engine_tb.sv @@
// Self-checking testbench for the text console cursor engine.
module text_console_cursor_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_PAD   = 16;
    localparam int LONG_HOLD   = 120;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_cmd_item   cmd_item;
    logic        empty;
    logic        pop;
    t_res_item   res_item;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    text_console_cursor_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd_item  (cmd_item),
        .empty       (empty),
        .pop         (pop),
        .o_res_item  (res_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // console model state
    int m_white;
    int m_wc;
    int m_front;
    int m_back;
    int m_shown;
    int m_lo;
    int m_px;
    int m_py;

    t_res_item step_acts[$];
    t_res_item due_results[$];

    bit idle_en;
    int rx_hold_req;
    int fail_cnt;
    int n_cmds;
    int n_results;
    int n_row_clears;
    int n_wraps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void console_reset();
        m_white = WHITE_RESET;
        m_wc    = 0;
        m_front = 0;
        m_back  = 0;
        m_shown = 0;
        m_lo    = 0;
        m_px    = 0;
        m_py    = 0;
    endfunction

    function automatic void note_action(input t_kind k, input int addr, input int ch,
                                        input int col);
        t_res_item r;
        r           = '0;
        r.kind      = k;
        r.address   = addr[11:0];
        r.out_char  = ch[7:0];
        r.out_color = col[7:0];
        step_acts.push_back(r);
    endfunction

    function automatic void wrap_and_scroll();
        int target;
        if (m_wc >= STORE_CELLS) begin
            m_wc = 0;
            n_wraps++;
        end
        target = (VISIBLE_CELLS + m_lo * COLS) % STORE_CELLS;
        if (m_wc == target) begin
            m_lo = (m_lo + 1) & 6'h3f;
            note_action(K_LINE, m_wc, CH_SPACE, m_white);
        end
    endfunction

    function automatic void place_cell(input int ch, input int col);
        note_action(K_WRITE, m_wc, ch, col);
        m_wc++;
        wrap_and_scroll();
    endfunction

    function automatic void update_pixels();
        int off;
        int row;
        int col;
        off  = (m_wc + STORE_CELLS - ((m_lo * COLS) % STORE_CELLS)) % STORE_CELLS;
        row  = off / COLS;
        col  = off % COLS;
        m_py = (GLYPH_H * row + 1) & 12'hfff;
        m_px = (col != COLS - 1) ? ((GLYPH_W * col + 1) & 12'hfff) : 1;
    endfunction

    // works out the results of one accepted command and queues them
    function automatic void console_step(input t_cmd_item it);
        t_res_item r;
        step_acts.delete();
        case (it.cmd)
            CMD_PUT: begin
                if (it.char_code == CH_NL) begin
                    m_wc = (m_wc / COLS) * COLS + COLS;
                    wrap_and_scroll();
                    if (step_acts.size() == 0)
                        note_action(K_CURSOR, 0, 0, 0);
                end else if (it.char_code == CH_TAB) begin
                    repeat (4) place_cell(CH_SPACE, m_white);
                end else if (it.char_code == CH_BS) begin
                    if (m_front < m_wc) begin
                        m_wc--;
                        note_action(K_ERASE, m_wc, 0, 0);
                    end else begin
                        note_action(K_CURSOR, 0, 0, 0);
                    end
                end else begin
                    place_cell(it.char_code, it.color_byte);
                end
                update_pixels();
            end
            CMD_BACK: begin
                note_action(K_WRITE, m_back, it.char_code, it.color_byte);
                m_back = (m_back + 1) % STORE_CELLS;
            end
            CMD_LOCK: begin
                m_front = m_wc;
                note_action(K_CURSOR, 0, 0, 0);
            end
            CMD_CLEAR: begin
                note_action(K_REGION, 0, CH_SPACE, m_white);
                m_shown = 0;
                m_back  = 0;
                m_wc    = 0;
                m_front = 0;
                m_lo    = 0;
                update_pixels();
            end
            CMD_SWITCH: begin
                m_shown ^= 1;
                if (m_shown != 0) begin
                    m_wc   = BACK_ROW * COLS;
                    m_back = 0;
                    m_lo   = BACK_ROW;
                end else begin
                    m_wc   = 0;
                    m_back = BACK_ROW * COLS;
                    m_lo   = 0;
                end
                note_action(K_CURSOR, 0, 0, 0);
            end
            default: ;
        endcase
        for (int i = 0; i < step_acts.size(); i++) begin
            r              = step_acts[i];
            r.pix_x        = m_px[11:0];
            r.pix_y        = m_py[11:0];
            r.scroll_lines = m_lo[5:0];
            r.last         = (i == step_acts.size() - 1);
            if (r.kind == K_LINE)
                n_row_clears++;
            due_results.push_back(r);
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void check_result(input t_res_item got);
        t_res_item want;
        if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d address %0d", got.kind, got.address);
            fail_cnt++;
            return;
        end
        want = due_results.pop_front();
        n_results++;
        cmp_field("kind", want.kind, got.kind);
        cmp_field("address", want.address, got.address);
        cmp_field("out_char", want.out_char, got.out_char);
        cmp_field("out_color", want.out_color, got.out_color);
        cmp_field("pix_x", want.pix_x, got.pix_x);
        cmp_field("pix_y", want.pix_y, got.pix_y);
        cmp_field("scroll_lines", want.scroll_lines, got.scroll_lines);
        cmp_field("last", want.last, got.last);
    endfunction

    // result side: checks each popped item, idles in bursts, honours long holds
    initial begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                check_result(res_item);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 6) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || cfg_we || (push && !full) || (pop && !empty))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic issue_command(input t_cmd_item it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push     <= 1'b1;
        cmd_item <= it;
        do @(posedge i_clk); while (full);
        console_step(it);
        if (it.cmd <= CMD_SWITCH)
            n_cmds++;
    endtask

    task automatic issue(input logic [2:0] c, input logic [7:0] ch, input logic [7:0] col);
        t_cmd_item it;
        it.cmd        = c;
        it.char_code  = ch;
        it.color_byte = col;
        issue_command(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic set_white(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        m_white = v;
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        issue(CMD_PUT, 8'h41, 8'h00);
        issue(CMD_PUT, 8'h00, 8'hff);
        issue(CMD_PUT, 8'hff, 8'haa);
        issue(CMD_PUT, CH_TAB, 8'h00);
        issue(CMD_PUT, CH_NL, 8'h12);
        issue(CMD_PUT, 8'h55, 8'h55);
        issue(CMD_PUT, CH_BS, 8'h00);
        issue(CMD_LOCK, 8'h00, 8'h00);
        issue(CMD_PUT, CH_BS, 8'hff);
        issue(CMD_BACK, 8'h55, 8'h55);
        issue(CMD_BACK, 8'haa, 8'h00);
        issue(CMD_SWITCH, 8'h00, 8'h00);
        issue(CMD_PUT, 8'h78, 8'h0f);
        issue(CMD_BACK, 8'h7f, 8'hf0);
        issue(CMD_SWITCH, 8'hff, 8'hff);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            issue(c[2:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        issue(CMD_PUT, CH_NL, 8'h00);
        issue(CMD_CLEAR, 8'h00, 8'h00);
        issue(CMD_PUT, 8'h20, 8'h80);
    endtask

    task automatic test_white_extremes();
        set_white(8'h00);
        issue(CMD_PUT, CH_TAB, 8'hff);
        issue(CMD_CLEAR, 8'h00, 8'h00);
        set_white(8'hff);
        issue(CMD_PUT, CH_TAB, 8'h00);
        issue(CMD_CLEAR, 8'h00, 8'h00);
    endtask

    // receiver holds off while commands keep coming, so the input stalls
    task automatic test_full_stall();
        drain();
        rx_hold_req = LONG_HOLD;
        for (int i = 0; i < 24; i++)
            issue(CMD_PUT, (i % 2) ? CH_TAB : 8'($urandom_range(32, 126)),
                  8'($urandom_range(0, 255)));
    endtask

    function automatic t_cmd_item random_command();
        t_cmd_item it;
        int r;
        r             = $urandom_range(0, 199);
        it.char_code  = 8'($urandom_range(0, 255));
        it.color_byte = 8'($urandom_range(0, 255));
        it.cmd        = CMD_PUT;
        if (r < 80)
            it.char_code = CH_NL;
        else if (r < 144)
            it.cmd = CMD_PUT;
        else if (r < 160)
            it.char_code = CH_TAB;
        else if (r < 174)
            it.char_code = CH_BS;
        else if (r < 180)
            it.cmd = CMD_LOCK;
        else if (r < 190)
            it.cmd = CMD_BACK;
        else if (r < 194)
            it.cmd = CMD_SWITCH;
        else if (r < 195)
            it.cmd = CMD_CLEAR;
        else
            it.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        return it;
    endfunction

    task automatic test_random_traffic(input int count, input logic [7:0] white,
                                       input bit with_idle);
        t_cmd_item it;
        int sent;
        set_white(white);
        idle_en = with_idle;
        sent    = 0;
        while (sent < count) begin
            it = random_command();
            issue_command(it);
            if (it.cmd <= CMD_SWITCH)
                sent++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        cmd_item    <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        idle_en      = 1'b1;
        rx_hold_req  = 0;
        fail_cnt     = 0;
        n_cmds       = 0;
        n_results    = 0;
        n_row_clears = 0;
        n_wraps      = 0;
        console_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_white_extremes();
        test_full_stall();
        test_random_traffic(100, 8'h00, 1'b1);
        test_random_traffic(100, 8'($urandom_range(1, 254)), 1'b1);
        test_random_traffic(100, 8'hff, 1'b1);
        test_random_traffic(100, 8'($urandom_range(0, 255)), 1'b0);

        drain();
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            fail_cnt++;
        end
        $display("Sent %0d commands and checked %0d results.", n_cmds, n_results);
        $display("Scrolled %0d rows, wrapped the store %0d times, %0d mismatches.",
                 n_row_clears, n_wraps, fail_cnt);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ text_console_cursor_engine.f @@
hdl/tcce_pkg.sv
hdl/tcce_jobq.sv
hdl/tcce_front.sv
hdl/tcce_back.sv
hdl/text_console_cursor_engine.sv
tb/text_console_cursor_engine_tb.sv
